### rtl/core/kct_pkg.sv
// kct_pkg: shared types and constants for the k-mer count table
// no dependencies
package kct_pkg;

   localparam logic [5:0] LEN_RESET = 6'd21;
   localparam int unsigned HASH_SEED = 5381;

   // table depth, a power of two so the hash low bits give the home slot
   localparam int TABLE_ENTRIES = 4096;

   localparam logic [0:0] FUNC_INSERT = 1'b0;
   localparam logic [0:0] FUNC_BASE = 1'b1;

   localparam logic [0:0] KIND_INSERT = 1'b0;
   localparam logic [0:0] KIND_MATCH = 1'b1;

   localparam logic [1:0] ST_NEW = 2'd0;
   localparam logic [1:0] ST_ADDED = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // ascii codes of the letters used by the hash
   localparam logic [6:0] LETTER_A = 7'd65;
   localparam logic [6:0] LETTER_C = 7'd67;
   localparam logic [6:0] LETTER_G = 7'd71;
   localparam logic [6:0] LETTER_T = 7'd84;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HASH,
      S_READ,
      S_WAIT,
      S_CHECK,
      S_WRITE,
      S_CLEAR,
      S_OUT
   } back_state_type;

   // item handed from the front to the back
   typedef struct packed {
      logic        lookup;     // 1 window lookup, 0 insert
      logic [63:0] key;
      logic [63:0] key_rev;
      logic [31:0] count;
      logic [31:0] position;
      logic [5:0]  len;
   } job_type;

   function automatic logic [6:0] letter_of(input logic [1:0] b);
      logic [6:0] r;
      begin
         case (b)
            2'd0: r = LETTER_A;
            2'd1: r = LETTER_C;
            2'd2: r = LETTER_G;
            default: r = LETTER_T;
         endcase
         return r;
      end
   endfunction

endpackage

### rtl/core/kmer_count_table_window_scan.sv
// kmer_count_table_window_scan: top level of the k-mer count table
// depends on kct_pkg, kct_front, kct_back, kct_ram
//
// k-mer count table with a reference window scan. inserts add a read count to
// a stored k-mer (saturating) or make a new entry; reference bases slide a
// window and report forward and reverse complement counts. the front tracks
// the window and hands one job at a time through a one-entry queue to the
// back, which owns the single-port table ram. in the back a job is picked up,
// hashed over its kmer_length bases, probed at its home slot and the slots
// after it, and its result delivered; a window lookup hashes and probes twice
// and delivers only when a count is nonzero. the check step waits while an
// earlier result is still stalled. the input stalls while the queue holds a
// job the back has not taken. after reset a clearing pass empties the table;
// during it only one job is taken into the queue, though items that make no
// job are still accepted (csr writes are still taken).
module kmer_count_table_window_scan (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [5:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [63:0] req_read_kmer,
   input  logic [31:0] req_read_count,
   input  logic [2:0]  req_base,
   input  logic        req_new_sequence,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [1:0]  rsp_insert_status,
   output logic [31:0] rsp_position,
   output logic [31:0] rsp_fwd_count,
   output logic [31:0] rsp_rev_count
);
   logic [5:0] len_ff, len_in, len_eff;
   logic job_valid, job_stall;
   kct_pkg::job_type job;

   // zero acts as one, anything above 32 as 32
   assign len_in = csr_write_enable ? csr_write_data : len_ff;
   assign len_eff = (len_ff == 6'd0) ? 6'd1 : (len_ff > 6'd32) ? 6'd32 : len_ff;

   always_ff @(posedge clock) begin
      if (reset) len_ff <= kct_pkg::LEN_RESET;
      else len_ff <= len_in;
   end

   kct_front u_front (
      .clock(clock), .reset(reset), .len(len_eff),
      .in_valid(req_valid), .in_stall(req_stall),
      .func(req_func), .read_kmer(req_read_kmer), .read_count(req_read_count),
      .base(req_base), .new_sequence(req_new_sequence),
      .job_valid(job_valid), .job_stall(job_stall), .job(job)
   );

   kct_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job_stall(job_stall), .job(job),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_insert_status(rsp_insert_status), .rsp_position(rsp_position),
      .rsp_fwd_count(rsp_fwd_count), .rsp_rev_count(rsp_rev_count)
   );
endmodule

### rtl/core/kct_ram.sv
// kct_ram: generic single-port ram with registered read
// no dependencies
module kct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

### rtl/core/kct_front.sv
// kct_front: accepts items, tracks the scan window and builds table jobs
// depends on kct_pkg
module kct_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [5:0]           len,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  logic                 func,
   input  logic [63:0]          read_kmer,
   input  logic [31:0]          read_count,
   input  logic [2:0]           base,
   input  logic                 new_sequence,
   output logic                 job_valid,
   input  logic                 job_stall,
   output kct_pkg::job_type     job
);
   logic [63:0] win_ff, win_in;
   logic [5:0]  skip_ff, skip_in;
   logic [31:0] seen_ff, seen_in;
   logic        jv_ff, jv_in;
   kct_pkg::job_type job_ff, job_in;
   logic [63:0] mask, w, wb, rc;
   logic [5:0]  s0;
   logic [31:0] sn;
   logic        is_n, acc;

   assign in_stall = jv_ff && job_stall;
   assign acc = in_valid && !in_stall;
   assign job_valid = jv_ff;
   assign job = job_ff;

   always_comb begin
      mask = (len == 6'd32) ? '1 : ((64'd1 << {len, 1'b0}) - 64'd1);
      is_n = base > 3'd3;
      wb = new_sequence ? 64'd0 : win_ff;
      s0 = new_sequence ? 6'd0 : skip_ff;
      sn = new_sequence ? 32'd0 : seen_ff;
      win_in = win_ff;
      skip_in = skip_ff;
      seen_in = seen_ff;
      jv_in = jv_ff && job_stall;
      job_in = job_ff;
      w = {wb[61:0], is_n ? 2'd0 : base[1:0]} & mask;
      rc = '0;
      for (int i = 0; i < 32; i++) begin
         if (i < int'(len)) begin
            rc[2*i +: 2] = 2'd3 - w[2*(int'(len)-1-i) +: 2];
         end
      end
      if (acc) begin
         if (func == kct_pkg::FUNC_INSERT) begin
            jv_in = 1'b1;
            job_in.lookup = 1'b0;
            job_in.key = read_kmer & mask;
            job_in.key_rev = '0;
            job_in.count = read_count;
            job_in.position = '0;
            job_in.len = len;
         end else begin
            win_in = {wb[61:0], is_n ? 2'd0 : base[1:0]};
            seen_in = (sn == '1) ? sn : sn + 32'd1;
            if (is_n) s0 = len;
            if (s0 != 6'd0) begin
               skip_in = s0 - 6'd1;
            end else begin
               skip_in = s0;
               if (seen_in >= {26'd0, len}) begin
                  jv_in = 1'b1;
                  job_in.lookup = 1'b1;
                  job_in.key = w;
                  job_in.key_rev = rc;
                  job_in.count = '0;
                  job_in.position = seen_in - {26'd0, len};
                  job_in.len = len;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
         skip_ff <= '0;
         seen_ff <= '0;
         jv_ff <= 1'b0;
      end else begin
         win_ff <= win_in;
         skip_ff <= skip_in;
         seen_ff <= seen_in;
         jv_ff <= jv_in;
      end
      job_ff <= job_in;
   end
endmodule

### rtl/core/kct_back.sv
// kct_back: hashes, probes and updates the table, forms results
// depends on kct_pkg and kct_ram
module kct_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_stall,
   input  kct_pkg::job_type job,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_kind,
   output logic [1:0]       rsp_insert_status,
   output logic [31:0]      rsp_position,
   output logic [31:0]      rsp_fwd_count,
   output logic [31:0]      rsp_rev_count
);
   localparam int AW = $clog2(kct_pkg::TABLE_ENTRIES);

   kct_pkg::back_state_type st_ff, st_in;
   kct_pkg::job_type j_ff, j_in;
   logic [63:0] hash_ff, hash_in;
   logic [5:0]  step_ff, step_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [AW:0]   probes_ff, probes_in;
   logic        pass_ff, pass_in;    // 0 forward, 1 reverse
   logic [31:0] fwd_ff, fwd_in;
   logic [AW:0]   clr_ff, clr_in;
   logic        rv_ff, rv_in;
   logic        kind_ff, kind_in;
   logic [1:0]  stat_ff, stat_in;
   logic [31:0] pos_ff, pos_in, f_ff, f_in, r_ff, r_in;

   logic         we;
   logic [AW-1:0] addr;
   logic [96:0]  wdata, rdata;
   logic [63:0]  key_cur, sh;
   logic [31:0]  sum;
   logic [32:0]  sum_w;

   kct_ram #(.WIDTH(97), .DEPTH(kct_pkg::TABLE_ENTRIES)) u_ram (
      .clock(clock), .wr_en(we), .addr(addr), .wr_data(wdata), .rd_data(rdata)
   );

   assign job_stall = (st_ff != kct_pkg::S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_kind = kind_ff;
   assign rsp_insert_status = stat_ff;
   assign rsp_position = pos_ff;
   assign rsp_fwd_count = f_ff;
   assign rsp_rev_count = r_ff;

   always_comb begin
      st_in = st_ff;
      j_in = j_ff;
      hash_in = hash_ff;
      step_in = step_ff;
      slot_in = slot_ff;
      probes_in = probes_ff;
      pass_in = pass_ff;
      fwd_in = fwd_ff;
      clr_in = clr_ff;
      rv_in = rv_ff && rsp_stall;
      kind_in = kind_ff;
      stat_in = stat_ff;
      pos_in = pos_ff;
      f_in = f_ff;
      r_in = r_ff;
      we = 1'b0;
      addr = slot_ff;
      wdata = '0;
      key_cur = pass_ff ? j_ff.key_rev : j_ff.key;
      sh = key_cur >> {step_ff - 6'd1, 1'b0};
      sum_w = {1'b0, rdata[31:0]} + {1'b0, j_ff.count};
      sum = sum_w[32] ? '1 : sum_w[31:0];
      unique case (st_ff)
         kct_pkg::S_CLEAR: begin
            we = 1'b1;
            addr = clr_ff[AW-1:0];
            wdata = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(kct_pkg::TABLE_ENTRIES - 1)) st_in = kct_pkg::S_IDLE;
         end
         kct_pkg::S_IDLE: begin
            if (job_valid) begin
               j_in = job;
               pass_in = 1'b0;
               st_in = kct_pkg::S_HASH;
               hash_in = 64'(kct_pkg::HASH_SEED);
               step_in = job.len;
            end
         end
         kct_pkg::S_HASH: begin
            // one base per cycle, first base first; times 33 as shift and add
            hash_in = (hash_ff << 5) + hash_ff + {57'd0, kct_pkg::letter_of(sh[1:0])};
            step_in = step_ff - 6'd1;
            if (step_ff == 6'd1) st_in = kct_pkg::S_READ;
         end
         kct_pkg::S_READ: begin
            slot_in = hash_ff[AW-1:0];
            probes_in = '0;
            st_in = kct_pkg::S_WAIT;
         end
         kct_pkg::S_WAIT: st_in = kct_pkg::S_CHECK;
         kct_pkg::S_CHECK: begin
            // an earlier result still stalled owns the result registers
            if (rv_ff && rsp_stall) begin
               st_in = kct_pkg::S_CHECK;
            end else if (!rdata[96] || rdata[95:32] == key_cur) begin
               if (j_ff.lookup) begin
                  if (!pass_ff) begin
                     fwd_in = rdata[96] ? rdata[31:0] : '0;
                     pass_in = 1'b1;
                     hash_in = 64'(kct_pkg::HASH_SEED);
                     step_in = j_ff.len;
                     st_in = kct_pkg::S_HASH;
                  end else begin
                     kind_in = kct_pkg::KIND_MATCH;
                     stat_in = kct_pkg::ST_NEW;
                     pos_in = j_ff.position;
                     f_in = fwd_ff;
                     r_in = rdata[96] ? rdata[31:0] : '0;
                     st_in = (fwd_ff != 0 || (rdata[96] && rdata[31:0] != 0)) ?
                             kct_pkg::S_OUT : kct_pkg::S_IDLE;
                  end
               end else begin
                  we = 1'b1;
                  kind_in = kct_pkg::KIND_INSERT;
                  pos_in = '0; f_in = '0; r_in = '0;
                  if (rdata[96]) begin
                     wdata = {1'b1, j_ff.key, sum};
                     stat_in = kct_pkg::ST_ADDED;
                  end else begin
                     wdata = {1'b1, j_ff.key, j_ff.count};
                     stat_in = kct_pkg::ST_NEW;
                  end
                  st_in = kct_pkg::S_OUT;
               end
            end else if (probes_ff == (AW+1)'(kct_pkg::TABLE_ENTRIES - 1)) begin
               if (j_ff.lookup) begin
                  if (!pass_ff) begin
                     fwd_in = '0;
                     pass_in = 1'b1;
                     hash_in = 64'(kct_pkg::HASH_SEED);
                     step_in = j_ff.len;
                     st_in = kct_pkg::S_HASH;
                  end else begin
                     kind_in = kct_pkg::KIND_MATCH;
                     stat_in = kct_pkg::ST_NEW;
                     pos_in = j_ff.position;
                     f_in = fwd_ff;
                     r_in = '0;
                     st_in = (fwd_ff != 0) ? kct_pkg::S_OUT : kct_pkg::S_IDLE;
                  end
               end else begin
                  kind_in = kct_pkg::KIND_INSERT;
                  stat_in = kct_pkg::ST_FULL;
                  pos_in = '0; f_in = '0; r_in = '0;
                  st_in = kct_pkg::S_OUT;
               end
            end else begin
               slot_in = slot_ff + 1'b1;
               probes_in = probes_ff + 1'b1;
               addr = slot_ff + 1'b1;
               st_in = kct_pkg::S_WAIT;
            end
         end
         kct_pkg::S_WRITE: st_in = kct_pkg::S_OUT;
         kct_pkg::S_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               st_in = kct_pkg::S_IDLE;
            end else begin
               rv_in = 1'b1;
            end
         end
         default: st_in = kct_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= kct_pkg::S_CLEAR;
         clr_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         clr_ff <= clr_in;
         rv_ff <= rv_in;
      end
      j_ff <= j_in;
      hash_ff <= hash_in;
      step_ff <= step_in;
      slot_ff <= slot_in;
      probes_ff <= probes_in;
      pass_ff <= pass_in;
      fwd_ff <= fwd_in;
      if (!(rv_ff && rsp_stall)) begin
         kind_ff <= kind_in;
         stat_ff <= stat_in;
         pos_ff <= pos_in;
         f_ff <= f_in;
         r_ff <= r_in;
      end
   end
endmodule
